/* hdl/kwdt_pkg.sv */
// Shared types and constants for the keyed watchdog timer.
// Used by kwdt_core and keyed_watchdog_timer; no dependencies.
package kwdt_pkg;

    localparam int ADDR_W  = 10;
    localparam int DATA_W  = 32;
    localparam int CTRL_W  = 24;
    localparam int COUNT_W = 33;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [ADDR_W-1:0] OFS_CONTROL = 10'h000;
    localparam logic [ADDR_W-1:0] OFS_CLEAR   = 10'h004;
    localparam logic [ADDR_W-1:0] OFS_STATUS  = 10'h008;
    localparam logic [ADDR_W-1:0] OFS_VERSION = 10'h3FC;

    localparam logic [CTRL_W-1:0] CONTROL_RESET    = 24'h010080;
    localparam logic [7:0]        KEY_FIRST        = 8'h55;
    localparam logic [7:0]        KEY_SECOND       = 8'hAA;
    localparam logic [DATA_W-1:0] CLEAR_FIRST      = 32'h5500_0001;
    localparam logic [DATA_W-1:0] CLEAR_SECOND     = 32'hAA00_0001;
    localparam logic [DATA_W-1:0] VERSION_VALUE    = 32'h0000_0410;
    localparam logic [DATA_W-1:0] WRITE_ONLY_VALUE = 32'hDEAD_BEEF;
    localparam logic [1:0]        STATUS_BOTH      = 2'b11;

    localparam int BIT_EN  = 0;
    localparam int BIT_DAR = 1;
    localparam int PS_LO   = 8;
    localparam int PS_HI   = 12;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                reset_request;
        logic                access_error;
    } t_result;

endpackage

/* hdl/kwdt_core.sv */
// Watchdog register file, key sequencing and countdown.
// Computes one result per request and updates state when i_step is high.
// Depends on kwdt_pkg.
module kwdt_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  kwdt_pkg::t_request i_req,
    output kwdt_pkg::t_result  o_res
);

    logic [kwdt_pkg::CTRL_W-1:0]  r_control,       n_control;
    logic [kwdt_pkg::DATA_W-1:0]  r_pend_ctrl,     n_pend_ctrl;
    logic [kwdt_pkg::DATA_W-1:0]  r_pend_clear,    n_pend_clear;
    logic [1:0]                   r_status,        n_status;
    logic [kwdt_pkg::COUNT_W-1:0] r_countdown,     n_countdown;
    logic                         r_counting,      n_counting;

    logic [4:0]                   ps;
    logic [5:0]                   shift;
    logic [kwdt_pkg::COUNT_W-1:0] dec;

    assign ps    = r_control[kwdt_pkg::PS_HI:kwdt_pkg::PS_LO];
    assign shift = {1'b0, ps} + 6'd1;
    assign dec   = r_countdown - {{(kwdt_pkg::COUNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_control    = r_control;
        n_pend_ctrl  = r_pend_ctrl;
        n_pend_clear = r_pend_clear;
        n_status     = r_status;
        n_countdown  = r_countdown;
        n_counting   = r_counting;
        o_res        = '0;
        case (i_req.opcode)
            kwdt_pkg::OP_READ: begin
                case (i_req.address)
                    kwdt_pkg::OFS_CONTROL: o_res.read_data = {8'h00, r_control};
                    kwdt_pkg::OFS_CLEAR:   o_res.read_data = kwdt_pkg::WRITE_ONLY_VALUE;
                    kwdt_pkg::OFS_STATUS:  o_res.read_data = {30'd0, r_status};
                    kwdt_pkg::OFS_VERSION: o_res.read_data = kwdt_pkg::VERSION_VALUE;
                    default:               o_res.access_error = 1'b1;
                endcase
            end
            kwdt_pkg::OP_WRITE: begin
                if (i_req.address == kwdt_pkg::OFS_CONTROL) begin
                    if (i_req.write_data[31:24] == kwdt_pkg::KEY_FIRST) begin
                        n_pend_ctrl = i_req.write_data;
                    end else if (i_req.write_data[31:24] == kwdt_pkg::KEY_SECOND &&
                                 r_pend_ctrl[31:24] == kwdt_pkg::KEY_FIRST) begin
                        if (i_req.write_data[23:0] == r_pend_ctrl[23:0]) begin
                            n_control = i_req.write_data[23:0];
                        end
                        n_pend_ctrl = '0;
                    end
                end else if (i_req.address == kwdt_pkg::OFS_CLEAR) begin
                    if (r_pend_clear == kwdt_pkg::CLEAR_FIRST &&
                        i_req.write_data == kwdt_pkg::CLEAR_SECOND) begin
                        n_pend_clear = '0;
                        n_countdown  = {{(kwdt_pkg::COUNT_W-1){1'b0}}, 1'b1} << shift;
                        n_counting   = ~r_control[kwdt_pkg::BIT_DAR];
                        n_status     = kwdt_pkg::STATUS_BOTH;
                    end else begin
                        n_pend_clear = i_req.write_data;
                    end
                end
            end
            kwdt_pkg::OP_TICK: begin
                if (r_counting) begin
                    n_countdown = dec;
                    if (dec == '0) begin
                        n_counting          = 1'b0;
                        o_res.reset_request = r_control[kwdt_pkg::BIT_EN];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= kwdt_pkg::CONTROL_RESET;
            r_pend_ctrl  <= '0;
            r_pend_clear <= '0;
            r_status     <= kwdt_pkg::STATUS_BOTH;
            r_countdown  <= '0;
            r_counting   <= 1'b0;
        end else if (i_step) begin
            r_control    <= n_control;
            r_pend_ctrl  <= n_pend_ctrl;
            r_pend_clear <= n_pend_clear;
            r_status     <= n_status;
            r_countdown  <= n_countdown;
            r_counting   <= n_counting;
        end
    end

endmodule

/* hdl/keyed_watchdog_timer.sv */
// Top level of the keyed watchdog timer: stream channels, input and result registers.
// Depends on kwdt_pkg and kwdt_core.
//
// Usage:
//   Each slave-side transaction is one request: tuser carries the opcode
//   (read, write, watchdog tick), tdata the byte address and write data.
//   Each request yields exactly one master-side transaction holding the
//   read data, the reset request flag and the access error flag.
//   After acceptance, a request passes the input register, then the state
//   update and the result register. Throughput is one request per cycle,
//   sustained while m_axis_tready stays high; the only loop is the
//   registered state update in kwdt_core.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; after that s_axis_tready
//   drops until the result is taken. Nothing is lost or repeated.
//   Synchronous active-low reset empties both registers and returns the
//   watchdog to its reset state: control 0x010080, timer stopped.
//   The watchdog tick rate is set by whoever issues tick requests.
module keyed_watchdog_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [9:0] address, [41:10] write_data, [47:42] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] read_data
    output logic [1:0]  m_axis_tuser   // [0] reset_request, [1] access_error
);

    logic               r_in_valid;
    kwdt_pkg::t_request r_in;
    logic               r_out_valid;
    kwdt_pkg::t_result  r_out;
    kwdt_pkg::t_result  core_res;
    logic               out_free;
    logic               step;

    assign out_free      = ~r_out_valid | m_axis_tready;
    assign step          = r_in_valid & out_free;
    assign s_axis_tready = ~r_in_valid | out_free;

    kwdt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.opcode     <= kwdt_pkg::t_opcode'(s_axis_tuser);
            r_in.address    <= s_axis_tdata[9:0];
            r_in.write_data <= s_axis_tdata[41:10];
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.read_data;
    assign m_axis_tuser[0] = r_out.reset_request;
    assign m_axis_tuser[1] = r_out.access_error;

endmodule
